// ===== sv/ray_box_slab_test_unit_assert.svh =====
// Assertion macros for the ray/box slab test unit checker.
// Expects signals named clk and arst_n in the scope of use.
`ifndef RAY_BOX_SLAB_TEST_UNIT_ASSERT_SVH
`define RAY_BOX_SLAB_TEST_UNIT_ASSERT_SVH

// Same-cycle property, disabled while reset is low.
`define RBST_PROP(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Condition this cycle implies consequence next cycle.
`define RBST_PROP_NEXT(lbl, ante, cons, msg) `RBST_PROP(lbl, (ante) |=> (cons), msg)

`endif

// ===== sv/rbst_pkg.sv =====
// Package for the ray/box slab test unit: widths, types, register indexes.
// No dependencies.
`default_nettype none
package rbst_pkg;

	localparam int COORD_W   = 32;
	localparam int FRAC_BITS = 16;
	localparam int EXT_W     = COORD_W - 1;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int PROD_W    = DIFF_W + COORD_W;
	localparam int NUM_CFG   = 6;
	localparam int NUM_AXES  = 3;
	localparam int CFG_IDX_W = 3;
	localparam int PIPE_DEPTH = 7;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [EXT_W-1:0]          ext_t;
	typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BOX_MIN_X = 3'd0,
		REG_BOX_MIN_Y = 3'd1,
		REG_BOX_MIN_Z = 3'd2,
		REG_BOX_MAX_X = 3'd3,
		REG_BOX_MAX_Y = 3'd4,
		REG_BOX_MAX_Z = 3'd5
	} cfg_reg_e;

	// load enables for the three stages of a bound lane
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} lane_en_t;

	// running interval along the ray
	typedef struct packed {
		logic   miss;
		coord_t t0;
		coord_t t1;
	} trk_t;

endpackage
`default_nettype wire

// ===== sv/rbst_ray_if.sv =====
// Ray input channel: valid/ready plus origin, reciprocal direction, extent.
// Depends on rbst_pkg.
`default_nettype none
interface rbst_ray_if;
	import rbst_pkg::*;

	logic   valid;
	logic   ready;
	coord_t origin_x;
	coord_t origin_y;
	coord_t origin_z;
	coord_t inv_dir_x;
	coord_t inv_dir_y;
	coord_t inv_dir_z;
	ext_t   ray_extent;

	modport source (output valid, origin_x, origin_y, origin_z,
		inv_dir_x, inv_dir_y, inv_dir_z, ray_extent, input ready);
	modport sink (input valid, origin_x, origin_y, origin_z,
		inv_dir_x, inv_dir_y, inv_dir_z, ray_extent, output ready);
	modport mon (input valid, ready, origin_x, origin_y, origin_z,
		inv_dir_x, inv_dir_y, inv_dir_z, ray_extent);
endinterface
`default_nettype wire

// ===== sv/rbst_res_if.sv =====
// Result channel: valid/ready plus hit flag and entry/exit distances.
// Depends on rbst_pkg.
`default_nettype none
interface rbst_res_if;
	import rbst_pkg::*;

	logic   valid;
	logic   ready;
	logic   hit;
	ext_t   t_enter;
	coord_t t_exit;

	modport source (output valid, hit, t_enter, t_exit, input ready);
	modport sink (input valid, hit, t_enter, t_exit, output ready);
	modport mon (input valid, ready, hit, t_enter, t_exit);
endinterface
`default_nettype wire

// ===== sv/rbst_cfg_if.sv =====
// Configuration write channel: valid/ready, register index and data.
// Depends on rbst_pkg.
`default_nettype none
interface rbst_cfg_if;
	import rbst_pkg::*;

	logic     valid;
	logic     ready;
	cfg_idx_t index;
	coord_t   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
	modport mon (input valid, ready, index, data);
endinterface
`default_nettype wire

// ===== sv/rbst_cfg_regs.sv =====
// Box corner registers written through the configuration channel.
// Depends on rbst_pkg and rbst_cfg_if.
`default_nettype none
module rbst_cfg_regs (
	input  wire logic       clk,
	input  wire logic       arst_n,
	rbst_cfg_if.sink        cfg,
	output rbst_pkg::coord_t box [rbst_pkg::NUM_CFG]
);
	import rbst_pkg::*;

	coord_t box_q [NUM_CFG];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CFG; i++) box_q[i] <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_BOX_MIN_X: box_q[0] <= cfg.data;
				REG_BOX_MIN_Y: box_q[1] <= cfg.data;
				REG_BOX_MIN_Z: box_q[2] <= cfg.data;
				REG_BOX_MAX_X: box_q[3] <= cfg.data;
				REG_BOX_MAX_Y: box_q[4] <= cfg.data;
				REG_BOX_MAX_Z: box_q[5] <= cfg.data;
				default: ; // unused index, write dropped
			endcase
		end
	end

	assign box = box_q;
endmodule
`default_nettype wire

// ===== sv/rbst_slab_lane.sv =====
// One slab bound: (box - origin) * inv_dir, floor shift, saturate.
// Three register stages. Depends on rbst_pkg.
`default_nettype none
module rbst_slab_lane (
	input  wire logic              clk,
	input  rbst_pkg::lane_en_t     en,
	input  rbst_pkg::coord_t       box,
	input  rbst_pkg::coord_t       origin,
	input  rbst_pkg::coord_t       inv_dir,
	output rbst_pkg::coord_t       bound_s3
);
	import rbst_pkg::*;

	localparam int TOP_W = PROD_W - (FRAC_BITS + COORD_W - 1);

	logic signed [DIFF_W-1:0] diff_s1;
	coord_t                   inv_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic [TOP_W-1:0]         top_bits;
	coord_t                   sat_val;

	// s1: exact difference
	always_ff @(posedge clk) begin
		if (en.s1) begin
			diff_s1 <= {box[COORD_W-1], box} - {origin[COORD_W-1], origin};
			inv_s1  <= inv_dir;
		end
	end

	// s2: exact signed product
	always_ff @(posedge clk) begin
		if (en.s2) begin
			prod_s2 <= PROD_W'($signed(diff_s1) * $signed(inv_s1));
		end
	end

	// arithmetic shift is floor; out of range when upper bits are not all sign
	assign top_bits = prod_s2[PROD_W-1 -: TOP_W];

	always_comb begin
		if ((&top_bits) || !(|top_bits)) begin
			sat_val = prod_s2[FRAC_BITS +: COORD_W];
		end else if (prod_s2[PROD_W-1]) begin
			sat_val = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			sat_val = {1'b0, {(COORD_W-1){1'b1}}};
		end
	end

	// s3: saturated bound
	always_ff @(posedge clk) begin
		if (en.s3) begin
			bound_s3 <= sat_val;
		end
	end
endmodule
`default_nettype wire

// ===== sv/rbst_axis_step.sv =====
// One axis update of the ray interval: clamp by near/far, flag a miss.
// Combinational. Depends on rbst_pkg.
`default_nettype none
module rbst_axis_step (
	input  rbst_pkg::trk_t   trk_in,
	input  rbst_pkg::coord_t near,
	input  rbst_pkg::coord_t far,
	output rbst_pkg::trk_t   trk_out
);
	import rbst_pkg::*;

	coord_t t0_n;
	coord_t t1_n;

	always_comb begin
		t0_n = (near > trk_in.t0) ? near : trk_in.t0;
		t1_n = (far < trk_in.t1) ? far : trk_in.t1;
		if (trk_in.miss) begin
			trk_out = trk_in; // earlier axis already missed
		end else begin
			trk_out.miss = (t0_n > t1_n);
			trk_out.t0   = t0_n;
			trk_out.t1   = t1_n;
		end
	end
endmodule
`default_nettype wire

// ===== sv/ray_box_slab_test_unit.sv =====
// Ray vs axis-aligned box slab test, signed Q16.16.
// Throughput: one ray word per cycle while the output is not stalled; set by the seven-stage pipeline.
// Reset (arst_n low, async): pipeline emptied, box registers cleared to 0.
// Config writes are taken every cycle (ready held high).
`default_nettype none
module ray_box_slab_test_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	rbst_ray_if.sink  ray,
	rbst_res_if.source res,
	rbst_cfg_if.sink  cfg
);
	import rbst_pkg::*;

	// Stages:
	//   s1 box - origin for all six bounds
	//   s2 products
	//   s3 floor shift and saturation
	//   s4 swap each axis pair into near/far
	//   s5 X clamp, s6 Y clamp, s7 Z clamp (output register)
	// Each stage loads when it is empty or the next one loads, so bubbles
	// collapse and a stall freezes only the full stages behind it.

	coord_t box [NUM_CFG];
	coord_t org [NUM_AXES];
	coord_t inv [NUM_AXES];
	coord_t bound_s3 [NUM_CFG];

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

	lane_en_t lane_en;

	ext_t ext_s1, ext_s2, ext_s3;
	coord_t near_s4 [NUM_AXES];
	coord_t far_s4 [NUM_AXES];
	ext_t   ext_s4;

	trk_t trk_init, trk_x, trk_y, trk_z;
	trk_t trk_s5, trk_s6, trk_s7;

	rbst_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.box    (box)
	);

	// ready chain from the output back to the input
	assign rdy7 = !v_s7 || res.ready;
	assign rdy6 = !v_s6 || rdy7;
	assign rdy5 = !v_s5 || rdy6;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign ray.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= ray.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
			if (rdy7) v_s7 <= v_s6;
		end
	end

	// s1..s3: six bound lanes, mins in 0..2, maxes in 3..5
	assign org[0] = ray.origin_x;
	assign org[1] = ray.origin_y;
	assign org[2] = ray.origin_z;
	assign inv[0] = ray.inv_dir_x;
	assign inv[1] = ray.inv_dir_y;
	assign inv[2] = ray.inv_dir_z;

	assign lane_en.s1 = rdy1;
	assign lane_en.s2 = rdy2;
	assign lane_en.s3 = rdy3;

	for (genvar g = 0; g < NUM_CFG; g++) begin : g_lane
		rbst_slab_lane u_lane (
			.clk      (clk),
			.en       (lane_en),
			.box      (box[g]),
			.origin   (org[g % NUM_AXES]),
			.inv_dir  (inv[g % NUM_AXES]),
			.bound_s3 (bound_s3[g])
		);
	end

	// extent rides alongside the lanes
	always_ff @(posedge clk) begin
		if (rdy1) ext_s1 <= ray.ray_extent;
		if (rdy2) ext_s2 <= ext_s1;
		if (rdy3) ext_s3 <= ext_s2;
		if (rdy4) ext_s4 <= ext_s3;
	end

	// s4: order each pair
	always_ff @(posedge clk) begin
		if (rdy4) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				if (bound_s3[a] < bound_s3[a + NUM_AXES]) begin
					near_s4[a] <= bound_s3[a];
					far_s4[a]  <= bound_s3[a + NUM_AXES];
				end else begin
					near_s4[a] <= bound_s3[a + NUM_AXES];
					far_s4[a]  <= bound_s3[a];
				end
			end
		end
	end

	// s5..s7: clamp X, then Y, then Z; a miss freezes the interval
	assign trk_init.miss = 1'b0;
	assign trk_init.t0   = '0;
	assign trk_init.t1   = {1'b0, ext_s4};

	rbst_axis_step u_step_x (
		.trk_in (trk_init), .near (near_s4[0]), .far (far_s4[0]), .trk_out (trk_x)
	);

	// near/far for Y and Z must follow the item down the pipe
	coord_t near_y_s5, far_y_s5, near_z_s5, far_z_s5;
	coord_t near_z_s6, far_z_s6;

	always_ff @(posedge clk) begin
		if (rdy5) begin
			trk_s5    <= trk_x;
			near_y_s5 <= near_s4[1];
			far_y_s5  <= far_s4[1];
			near_z_s5 <= near_s4[2];
			far_z_s5  <= far_s4[2];
		end
	end

	rbst_axis_step u_step_y (
		.trk_in (trk_s5), .near (near_y_s5), .far (far_y_s5), .trk_out (trk_y)
	);

	always_ff @(posedge clk) begin
		if (rdy6) begin
			trk_s6    <= trk_y;
			near_z_s6 <= near_z_s5;
			far_z_s6  <= far_z_s5;
		end
	end

	rbst_axis_step u_step_z (
		.trk_in (trk_s6), .near (near_z_s6), .far (far_z_s6), .trk_out (trk_z)
	);

	always_ff @(posedge clk) begin
		if (rdy7) trk_s7 <= trk_z;
	end

	// result word; t0 never drops below zero so its top bit is clear
	assign res.valid   = v_s7;
	assign res.hit     = !trk_s7.miss;
	assign res.t_enter = trk_s7.t0[EXT_W-1:0];
	assign res.t_exit  = trk_s7.t1;
endmodule
`default_nettype wire

// ===== sv/rbst_checker.sv =====
// Port-level checker for ray_box_slab_test_unit, bound to the top level.
// Depends on rbst_pkg, the channel interfaces and the assertion macro header.
`default_nettype none
`include "ray_box_slab_test_unit_assert.svh"
module rbst_checker (
	input wire logic   clk,
	input wire logic   arst_n,
	rbst_ray_if.sink   ray,
	rbst_res_if.source res,
	rbst_cfg_if.sink   cfg
);
	import rbst_pkg::*;

	logic [3:0] cnt_q; // words in flight

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 4'(ray.valid && ray.ready) - 4'(res.valid && res.ready);
		end
	end

	// hit flag agrees with the reported interval
	`RBST_PROP(a_hit_interval, res.valid |-> (res.hit == ($signed({1'b0, res.t_enter}) <= res.t_exit)), "hit flag disagrees with interval")
	// no result word without a ray in flight
	`RBST_PROP(a_no_phantom, res.valid |-> (cnt_q != 4'd0), "result word without a ray in flight")
	// input backpressure only when the output is stalled
	`RBST_PROP(a_stall_source, !ray.ready |-> (res.valid && !res.ready), "input stalled while output free")
	// config port never stalls
	`RBST_PROP(a_cfg_ready, cfg.ready, "config port not ready")
	// stalled result word holds
	`RBST_PROP_NEXT(a_res_hold, res.valid && !res.ready, res.valid && $stable(res.hit) && $stable(res.t_enter) && $stable(res.t_exit), "stalled result word changed")
endmodule

bind ray_box_slab_test_unit rbst_checker u_rbst_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.ray    (ray),
	.res    (res),
	.cfg    (cfg)
);
`default_nettype wire
